@@ rtl/m3i_pkg.sv @@
package m3i_pkg;

  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int FRONT_LAT      = 6;
  localparam int NUM_ELEMS      = 9;

  // cofactor i = a[COF_A]*a[COF_B] - a[COF_C]*a[COF_D], sign already folded in
  localparam int COF_A [NUM_ELEMS] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
  localparam int COF_B [NUM_ELEMS] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
  localparam int COF_C [NUM_ELEMS] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
  localparam int COF_D [NUM_ELEMS] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

  // adjugate: inverse element r*3+c takes cofactor c*3+r
  localparam int ADJ_SRC [NUM_ELEMS] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

  function automatic int imax(input int x, input int y);
    return (x > y) ? x : y;
  endfunction

  function automatic int cof_width(input int ew);
    return 2 * ew + 1;
  endfunction

  function automatic int det_width(input int ew);
    return 3 * ew + 3;
  endfunction

  function automatic int lane_lat(input int ew);
    return ew + 4;
  endfunction

endpackage

@@ rtl/m3i_mat_if.sv @@
interface m3i_mat_if #(
  parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [ELEM_WIDTH-1:0] in_r0c0;
  logic signed [ELEM_WIDTH-1:0] in_r0c1;
  logic signed [ELEM_WIDTH-1:0] in_r0c2;
  logic signed [ELEM_WIDTH-1:0] in_r1c0;
  logic signed [ELEM_WIDTH-1:0] in_r1c1;
  logic signed [ELEM_WIDTH-1:0] in_r1c2;
  logic signed [ELEM_WIDTH-1:0] in_r2c0;
  logic signed [ELEM_WIDTH-1:0] in_r2c1;
  logic signed [ELEM_WIDTH-1:0] in_r2c2;

  modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, input ready);
  modport sink (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface m3i_inv_if #(
  parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [ELEM_WIDTH-1:0] inv_r0c0;
  logic signed [ELEM_WIDTH-1:0] inv_r0c1;
  logic signed [ELEM_WIDTH-1:0] inv_r0c2;
  logic signed [ELEM_WIDTH-1:0] inv_r1c0;
  logic signed [ELEM_WIDTH-1:0] inv_r1c1;
  logic signed [ELEM_WIDTH-1:0] inv_r1c2;
  logic signed [ELEM_WIDTH-1:0] inv_r2c0;
  logic signed [ELEM_WIDTH-1:0] inv_r2c1;
  logic signed [ELEM_WIDTH-1:0] inv_r2c2;
  logic singular;
  logic overflowed;

  modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                  inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular, overflowed,
                  input ready);
  modport sink (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular, overflowed,
                output ready);
endinterface

@@ rtl/mat3_inverse_by_adjugate.sv @@
// throughput: one matrix per cycle while the output is taken; nine pipelined restoring
// dividers, one quotient bit per stage, run side by side, one per inverse element
// the whole pipeline holds while the output word waits
// reset clears the valid pipeline only; data registers are not reset
module mat3_inverse_by_adjugate #(
  parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  m3i_mat_if.sink   mat_in,
  m3i_inv_if.source mat_out
);
  import m3i_pkg::*;

  localparam int E  = ELEM_WIDTH;
  localparam int CW = cof_width(E);
  localparam int DW = det_width(E);
  localparam int LL = lane_lat(E);
  localparam int L  = FRONT_LAT + LL + 1;

  logic                 en;
  logic [L-1:0]         vld;
  logic signed [E-1:0]  a_in [NUM_ELEMS];
  logic signed [CW-1:0] cof  [NUM_ELEMS];
  logic signed [DW-1:0] det;
  logic [E-1:0]         quo  [NUM_ELEMS];
  logic [NUM_ELEMS-1:0] ovf;
  logic [LL-1:0]        sing;
  logic [E-1:0]         inv  [NUM_ELEMS];
  logic                 singular, overflowed;

  assign en = !(vld[L-1] && !mat_out.ready);
  assign mat_in.ready = en;

  assign a_in[0] = mat_in.in_r0c0;
  assign a_in[1] = mat_in.in_r0c1;
  assign a_in[2] = mat_in.in_r0c2;
  assign a_in[3] = mat_in.in_r1c0;
  assign a_in[4] = mat_in.in_r1c1;
  assign a_in[5] = mat_in.in_r1c2;
  assign a_in[6] = mat_in.in_r2c0;
  assign a_in[7] = mat_in.in_r2c1;
  assign a_in[8] = mat_in.in_r2c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], mat_in.valid};
    end
  end

  m3i_front #(.ELEM_WIDTH(E), .CW(CW), .DW(DW)) u_front (
    .clk (clk),
    .en  (en),
    .a_in(a_in),
    .cof (cof),
    .det (det)
  );

  for (genvar i = 0; i < NUM_ELEMS; i++) begin : g_lane
    m3i_div_lane #(.ELEM_WIDTH(E), .FRAC_BITS(FRAC_BITS), .CW(CW), .DW(DW)) u_lane (
      .clk(clk),
      .en (en),
      .num(cof[ADJ_SRC[i]]),
      .den(det),
      .quo(quo[i]),
      .ovf(ovf[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing <= {sing[LL-2:0], det == '0};
    end
  end

  // merge the lanes into the output word
  always_ff @(posedge clk) begin
    if (en) begin
      singular   <= sing[LL-1];
      overflowed <= !sing[LL-1] && (|ovf);
      for (int i = 0; i < NUM_ELEMS; i++) begin
        inv[i] <= sing[LL-1] ? '0 : quo[i];
      end
    end
  end

  assign mat_out.valid      = vld[L-1];
  assign mat_out.singular   = singular;
  assign mat_out.overflowed = overflowed;
  assign mat_out.inv_r0c0   = inv[0];
  assign mat_out.inv_r0c1   = inv[1];
  assign mat_out.inv_r0c2   = inv[2];
  assign mat_out.inv_r1c0   = inv[3];
  assign mat_out.inv_r1c1   = inv[4];
  assign mat_out.inv_r1c2   = inv[5];
  assign mat_out.inv_r2c0   = inv[6];
  assign mat_out.inv_r2c1   = inv[7];
  assign mat_out.inv_r2c2   = inv[8];

  a_sing_no_ovf: assert property (@(posedge clk) disable iff (rst)
    mat_out.valid && mat_out.singular |-> !mat_out.overflowed)
    else $error("singular word flagged overflow");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    mat_out.valid && mat_out.singular |->
      mat_out.inv_r0c0 == '0 && mat_out.inv_r1c1 == '0 && mat_out.inv_r2c2 == '0)
    else $error("singular word with nonzero elements");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    en && vld[L-2] |=> mat_out.valid)
    else $error("word lost at the output stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");

endmodule

@@ rtl/m3i_front.sv @@
module m3i_front #(
  parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
  parameter int CW = m3i_pkg::cof_width(ELEM_WIDTH),
  parameter int DW = m3i_pkg::det_width(ELEM_WIDTH)
) (
  input  logic clk,
  input  logic en,
  input  logic signed [ELEM_WIDTH-1:0] a_in [m3i_pkg::NUM_ELEMS],
  output logic signed [CW-1:0] cof [m3i_pkg::NUM_ELEMS],
  output logic signed [DW-1:0] det
);
  import m3i_pkg::*;

  localparam int E  = ELEM_WIDTH;
  localparam int PW = 2 * E;
  localparam int TW = 3 * E + 1;

  logic signed [E-1:0]    a    [NUM_ELEMS];
  logic signed [PW-1:0]   p    [2*NUM_ELEMS];
  logic signed [E-1:0]    a2   [3];
  logic signed [E-1:0]    a3   [3];
  logic signed [CW-1:0]   c3   [NUM_ELEMS];
  logic signed [CW-1:0]   c4   [NUM_ELEMS];
  logic signed [CW-1:0]   c5   [NUM_ELEMS];
  logic signed [PW:0]     plo  [3];
  logic signed [PW:0]     phi  [3];
  logic signed [TW-1:0]   term [3];

  always_ff @(posedge clk) begin
    if (en) begin
      a <= a_in;
    end
  end

  // products of the 2x2 minors
  for (genvar i = 0; i < NUM_ELEMS; i++) begin : g_prod
    always_ff @(posedge clk) begin
      if (en) begin
        p[2*i]   <= a[COF_A[i]] * a[COF_B[i]];
        p[2*i+1] <= a[COF_C[i]] * a[COF_D[i]];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c3[i] <= CW'(p[2*i]) - CW'(p[2*i+1]);
        c4[i] <= c3[i];
        c5[i] <= c4[i];
        cof[i] <= c5[i];
      end
    end
  end

  // first-row expansion, cofactor split into low and high halves
  for (genvar i = 0; i < 3; i++) begin : g_det
    always_ff @(posedge clk) begin
      if (en) begin
        a2[i]  <= a[i];
        a3[i]  <= a2[i];
        plo[i] <= a3[i] * $signed({1'b0, c3[i][E-1:0]});
        phi[i] <= a3[i] * $signed(c3[i][CW-1:E]);
        term[i] <= (TW'(phi[i]) <<< E) + TW'(plo[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= DW'(term[0]) + DW'(term[1]) + DW'(term[2]);
    end
  end

endmodule

@@ rtl/m3i_div_lane.sv @@
module m3i_div_lane #(
  parameter int ELEM_WIDTH = m3i_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF,
  parameter int CW = m3i_pkg::cof_width(ELEM_WIDTH),
  parameter int DW = m3i_pkg::det_width(ELEM_WIDTH)
) (
  input  logic clk,
  input  logic en,
  input  logic signed [CW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic [ELEM_WIDTH-1:0] quo,
  output logic ovf
);
  import m3i_pkg::*;

  localparam int E  = ELEM_WIDTH;
  localparam int NW = CW + 1 + 2 * FRAC_BITS;
  localparam int W  = imax(NW, DW + E + 2) + 1;
  localparam int S  = E + 2;
  localparam logic [E:0] HALF = (E+1)'(1) << (E - 1);

  logic [CW:0]   ncx, nmag_c;
  logic [DW:0]   dcx, dmag_c;
  logic          neg_a;
  logic [W-1:0]  nmag, dmag;
  logic [W-1:0]  r   [S];
  logic [W-1:0]  d   [S];
  logic [E:0]    q   [S];
  logic          ng  [S];
  logic          pre [S];
  logic          big;

  assign ncx    = {num[CW-1], num};
  assign dcx    = {den[DW-1], den};
  assign nmag_c = num[CW-1] ? -ncx : ncx;
  assign dmag_c = den[DW-1] ? -dcx : dcx;

  // magnitudes and scaled numerator
  always_ff @(posedge clk) begin
    if (en) begin
      neg_a <= num[CW-1] ^ den[DW-1];
      nmag  <= W'(nmag_c) << (2 * FRAC_BITS);
      dmag  <= W'(dmag_c);
    end
  end

  // quotient needing more than E+1 bits is out of range anyway
  always_ff @(posedge clk) begin
    if (en) begin
      r[0]   <= nmag;
      d[0]   <= dmag;
      q[0]   <= '0;
      ng[0]  <= neg_a;
      pre[0] <= nmag >= (dmag << (E + 1));
    end
  end

  // one restoring step per stage
  for (genvar j = 0; j <= E; j++) begin : g_step
    logic [W-1:0] dsh;
    logic         take;
    assign dsh  = d[j] << (E - j);
    assign take = r[j] >= dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        r[j+1]   <= take ? r[j] - dsh : r[j];
        q[j+1]   <= {q[j][E-1:0], take};
        d[j+1]   <= d[j];
        ng[j+1]  <= ng[j];
        pre[j+1] <= pre[j];
      end
    end
  end

  assign big = pre[S-1] || (q[S-1] > (ng[S-1] ? HALF : HALF - 1'b1));

  always_ff @(posedge clk) begin
    if (en) begin
      ovf <= big;
      if (big) begin
        quo <= ng[S-1] ? HALF[E-1:0] : E'(HALF - 1'b1);
      end else begin
        quo <= ng[S-1] ? E'(-q[S-1]) : q[S-1][E-1:0];
      end
    end
  end

endmodule

@@ sim/mat3_inverse_by_adjugate_tb.sv @@
module mat3_inverse_by_adjugate_tb;
  import m3i_pkg::*;

  localparam int EW = ELEM_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int N_RANDOM = 1425;
  localparam int CALM_FROM = 1250;
  localparam int PRESSURE_AT = 300;
  localparam int PRESSURE_LEN = 300;
  localparam logic signed [EW-1:0] ONE = 1 <<< FB;
  localparam logic signed [EW-1:0] EMAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] EMIN = {1'b1, {(EW-1){1'b0}}};

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [191:0] wide_t;

  typedef struct {
    elem_t e[NUM_ELEMS];
  } matrix_t;

  typedef struct {
    elem_t e[NUM_ELEMS];
    logic  singular;
    logic  overflowed;
  } inverse_t;

  typedef struct {
    matrix_t  m;
    logic     typed;
    inverse_t inv;
  } row_t;

  logic clk;
  logic rst;

  m3i_mat_if #(.ELEM_WIDTH(EW)) mat_in ();
  m3i_inv_if #(.ELEM_WIDTH(EW)) mat_out ();

  mat3_inverse_by_adjugate #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) dut (
    .clk(clk),
    .rst(rst),
    .mat_in(mat_in.sink),
    .mat_out(mat_out.source)
  );

  inverse_t pending_inverses[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int n_singular = 0;
  int n_overflow = 0;
  bit calm = 0;
  bit sending_done = 0;

  string elem_names[NUM_ELEMS] = '{"inv_r0c0", "inv_r0c1", "inv_r0c2", "inv_r1c0",
    "inv_r1c1", "inv_r1c2", "inv_r2c0", "inv_r2c1", "inv_r2c2"};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic inverse_t invert_matrix(matrix_t m);
    wide_t a[NUM_ELEMS];
    wide_t cof[NUM_ELEMS];
    wide_t det;
    wide_t q;
    inverse_t r;
    r.singular = 0;
    r.overflowed = 0;
    for (int i = 0; i < NUM_ELEMS; i++) a[i] = m.e[i];
    for (int i = 0; i < NUM_ELEMS; i++)
      cof[i] = a[COF_A[i]] * a[COF_B[i]] - a[COF_C[i]] * a[COF_D[i]];
    det = a[0] * cof[0] + a[1] * cof[1] + a[2] * cof[2];
    if (det == 0) begin
      for (int i = 0; i < NUM_ELEMS; i++) r.e[i] = '0;
      r.singular = 1;
      return r;
    end
    for (int k = 0; k < NUM_ELEMS; k++) begin
      q = (cof[ADJ_SRC[k]] <<< (2 * FB)) / det;
      if (q > wide_t'(EMAX)) begin
        r.e[k] = EMAX;
        r.overflowed = 1;
      end else if (q < wide_t'(EMIN)) begin
        r.e[k] = EMIN;
        r.overflowed = 1;
      end else begin
        r.e[k] = q[EW-1:0];
      end
    end
    return r;
  endfunction

  function automatic matrix_t diag_matrix(elem_t d0, elem_t d1, elem_t d2);
    matrix_t m;
    for (int i = 0; i < NUM_ELEMS; i++) m.e[i] = '0;
    m.e[0] = d0;
    m.e[4] = d1;
    m.e[8] = d2;
    return m;
  endfunction

  function automatic matrix_t fill_matrix(elem_t v);
    matrix_t m;
    for (int i = 0; i < NUM_ELEMS; i++) m.e[i] = v;
    return m;
  endfunction

  function automatic elem_t random_elem(int kind);
    elem_t v;
    case (kind)
      0: v = $urandom();
      1: v = $signed($urandom_range(0, 8 << FB)) - (4 <<< FB);
      2: v = $signed($urandom_range(0, 512)) - 256;
      default: v = $signed($urandom_range(0, 1 << FB)) - (1 <<< (FB - 1));
    endcase
    return v;
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int kind;
    int shape;
    kind = $urandom_range(0, 3);
    shape = $urandom_range(0, 9);
    for (int i = 0; i < NUM_ELEMS; i++) m.e[i] = random_elem(kind);
    case (shape)
      0: begin
        // two equal rows
        for (int c = 0; c < 3; c++) m.e[3 + c] = m.e[c];
      end
      1: begin
        // zero column
        for (int r = 0; r < 3; r++) m.e[r * 3 + $urandom_range(0, 0)] = '0;
      end
      2: begin
        // near identity
        for (int i = 0; i < NUM_ELEMS; i++) m.e[i] = random_elem(2);
        m.e[0] += ONE;
        m.e[4] += ONE;
        m.e[8] += ONE;
      end
      3: begin
        for (int i = 0; i < NUM_ELEMS; i++)
          if ($urandom_range(0, 1)) m.e[i] = $urandom_range(0, 1) ? EMAX : EMIN;
      end
      default: ;
    endcase
    return m;
  endfunction

  task automatic send_matrix(matrix_t m, inverse_t expected);
    int gap;
    gap = calm ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(1, 16) : 0);
    if (gap > 0) begin
      mat_in.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    mat_in.valid <= 1;
    mat_in.in_r0c0 <= m.e[0];
    mat_in.in_r0c1 <= m.e[1];
    mat_in.in_r0c2 <= m.e[2];
    mat_in.in_r1c0 <= m.e[3];
    mat_in.in_r1c1 <= m.e[4];
    mat_in.in_r1c2 <= m.e[5];
    mat_in.in_r2c0 <= m.e[6];
    mat_in.in_r2c1 <= m.e[7];
    mat_in.in_r2c2 <= m.e[8];
    do @(posedge clk); while (!mat_in.ready);
    pending_inverses.push_back(expected);
    words_in++;
    if (expected.singular) n_singular++;
    if (expected.overflowed) n_overflow++;
  endtask

  // directed table
  row_t table_rows[$];

  task automatic add_row(matrix_t m, logic typed, inverse_t inv);
    row_t r;
    r.m = m;
    r.typed = typed;
    r.inv = inv;
    table_rows.push_back(r);
  endtask

  function automatic inverse_t flat_inverse(elem_t v, logic sing, logic ovf);
    inverse_t r;
    for (int i = 0; i < NUM_ELEMS; i++) r.e[i] = v;
    r.singular = sing;
    r.overflowed = ovf;
    return r;
  endfunction

  initial begin
    inverse_t none;
    inverse_t inv;
    matrix_t m;
    none = flat_inverse('0, 0, 0);
    rst <= 1;
    mat_in.valid <= 0;
    mat_in.in_r0c0 <= '0;
    mat_in.in_r0c1 <= '0;
    mat_in.in_r0c2 <= '0;
    mat_in.in_r1c0 <= '0;
    mat_in.in_r1c1 <= '0;
    mat_in.in_r1c2 <= '0;
    mat_in.in_r2c0 <= '0;
    mat_in.in_r2c1 <= '0;
    mat_in.in_r2c2 <= '0;
    mat_out.ready <= 0;
    repeat (7) @(posedge clk);
    rst <= 0;

    // identity inverts to itself
    inv = flat_inverse('0, 0, 0);
    inv.e[0] = ONE;
    inv.e[4] = ONE;
    inv.e[8] = ONE;
    add_row(diag_matrix(ONE, ONE, ONE), 1, inv);
    // diag 2.0 gives 0.5
    inv.e[0] = ONE >>> 1;
    inv.e[4] = ONE >>> 1;
    inv.e[8] = ONE >>> 1;
    add_row(diag_matrix(2 * ONE, 2 * ONE, 2 * ONE), 1, inv);
    // zero and all-equal are singular
    add_row(fill_matrix('0), 1, flat_inverse('0, 1, 0));
    add_row(fill_matrix(EMAX), 1, flat_inverse('0, 1, 0));
    add_row(fill_matrix(EMIN), 1, flat_inverse('0, 1, 0));
    add_row(fill_matrix('1), 1, flat_inverse('0, 1, 0));
    // smallest step on diagonal saturates high, its negative saturates low
    inv = flat_inverse('0, 0, 1);
    inv.e[0] = EMAX;
    inv.e[4] = EMAX;
    inv.e[8] = EMAX;
    add_row(diag_matrix(1, 1, 1), 1, inv);
    inv.e[0] = EMIN;
    inv.e[4] = EMIN;
    inv.e[8] = EMIN;
    add_row(diag_matrix(-1, -1, -1), 1, inv);
    // extremes, mixed signs and full matrices, predicted
    add_row(diag_matrix(EMAX, EMAX, EMAX), 0, none);
    add_row(diag_matrix(EMIN, EMIN, EMIN), 0, none);
    add_row(diag_matrix(EMIN, EMAX, -ONE), 0, none);
    add_row(diag_matrix(-ONE, ONE, -ONE), 0, none);
    add_row(diag_matrix(3 * ONE, -7 * ONE, ONE >>> 3), 0, none);
    for (int i = 0; i < NUM_ELEMS; i++) m.e[i] = (i + 1) * ONE;
    m.e[8] = 10 * ONE;
    add_row(m, 0, none);
    for (int i = 0; i < NUM_ELEMS; i++) m.e[i] = (i % 2) ? EMIN : EMAX;
    add_row(m, 0, none);
    for (int i = 0; i < NUM_ELEMS; i++) m.e[i] = (i % 4 == 0) ? EMIN : 1;
    add_row(m, 0, none);
    for (int i = 0; i < NUM_ELEMS; i++) m.e[i] = (i % 4 == 0) ? 2 * ONE : ONE;
    add_row(m, 0, none);
    // truncation toward zero on negative quotient, then an anti-diagonal permutation
    add_row(diag_matrix(-3 * ONE, 3 * ONE, 7 * ONE), 0, none);
    for (int i = 0; i < NUM_ELEMS; i++) m.e[i] = '0;
    m.e[2] = ONE;
    m.e[4] = ONE;
    m.e[6] = ONE;
    add_row(m, 0, none);

    foreach (table_rows[i])
      send_matrix(table_rows[i].m,
                  table_rows[i].typed ? table_rows[i].inv : invert_matrix(table_rows[i].m));

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == CALM_FROM) calm = 1;
      m = random_matrix();
      send_matrix(m, invert_matrix(m));
    end
    mat_in.valid <= 0;
    sending_done = 1;
  end

  // receiver: bursty ready, one long hold-off
  initial begin
    int stall;
    bit pressed;
    stall = 0;
    pressed = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!pressed && words_in >= PRESSURE_AT) begin
        pressed = 1;
        mat_out.ready <= 0;
        for (int c = 0; c < PRESSURE_LEN; c++) @(posedge clk);
      end
      if (calm) begin
        mat_out.ready <= 1;
      end else if (stall > 0) begin
        stall--;
        mat_out.ready <= 0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 15);
        mat_out.ready <= 0;
      end else begin
        mat_out.ready <= 1;
      end
    end
  end

  // result check
  always @(posedge clk) begin
    inverse_t want;
    elem_t got[NUM_ELEMS];
    if (!rst && mat_out.valid && mat_out.ready) begin
      got = '{mat_out.inv_r0c0, mat_out.inv_r0c1, mat_out.inv_r0c2, mat_out.inv_r1c0,
              mat_out.inv_r1c1, mat_out.inv_r1c2, mat_out.inv_r2c0, mat_out.inv_r2c1,
              mat_out.inv_r2c2};
      words_out++;
      if (pending_inverses.size() == 0) begin
        $error("unexpected output word");
        errors++;
      end else begin
        want = pending_inverses.pop_front();
        for (int i = 0; i < NUM_ELEMS; i++)
          if (got[i] !== want.e[i]) begin
            $error("%s expected %0d actual %0d", elem_names[i], want.e[i], got[i]);
            errors++;
          end
        if (mat_out.singular !== want.singular) begin
          $error("singular expected %0d actual %0d", want.singular, mat_out.singular);
          errors++;
        end
        if (mat_out.overflowed !== want.overflowed) begin
          $error("overflowed expected %0d actual %0d", want.overflowed, mat_out.overflowed);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (lane_lat(EW) + 20) @(posedge clk);
    $display("%0d matrices in, %0d inverses out; %0d singular, %0d saturated",
             words_in, words_out, n_singular, n_overflow);
    $display("covered extremes, bursty stalls on both sides and a long output hold-off");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
